@@ hdl/look_at_view_matrix_top_assert.svh @@
// Assertion macros shared by the look-at view matrix block.
`ifndef LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define LAV_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, quiet during reset.
`define LAV_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

@@ hdl/lav_pkg.sv @@
// Package: constants, types and the arctangent table of the look-at view matrix block.
`timescale 1ns / 1ps
package lav_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam logic [31:0] HEIGHT_RESET = 32'(1) << (COORD_FRAC_BITS - 1);

    localparam int NORM_LAT = 71;
    localparam logic [4:0] CORDIC_LAST = 5'd29;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [1:0] CFG_ORTHO_MODE   = 2'd0;
    localparam logic [1:0] CFG_ORTHO_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ORTHO_ROLL   = 2'd2;

    localparam logic [1:0] ROW_SIDE = 2'd0;
    localparam logic [1:0] ROW_UP   = 2'd1;
    localparam logic [1:0] ROW_BACK = 2'd2;

    // Data that rides alongside the normalisers
    typedef struct packed {
        logic [2:0][31:0] eye;
        logic [2:0][31:0] up;
        logic [2:0][31:0] back;
        logic [2:0][31:0] side;
        logic             ok;
    } t_side;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Signed 32 x 32 product, full 64 bit result
    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] ea;
        logic signed [63:0] eb;
        ea = $signed({{32{a[31]}}, a});
        eb = $signed({{32{b[31]}}, b});
        return 64'(ea * eb);
    endfunction

endpackage

@@ hdl/lav_norm.sv @@
// Pipelined vector normaliser: scale, square sum, square root, three divides.
`timescale 1ns / 1ps
module lav_norm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ce,
    input  logic             i_valid,
    input  logic [2:0][63:0] i_vec,
    input  lav_pkg::t_side   i_side,
    output logic             o_valid,
    output logic [2:0][31:0] o_vec,
    output logic             o_ok,
    output lav_pkg::t_side   o_side
);
    import lav_pkg::*;

    localparam int SQ = 32;
    localparam int DV = 31;

    typedef struct packed {
        logic [2:0][30:0] sm;
        logic [2:0]       sgn;
        logic             nz;
    } t_meta;

    logic [NORM_LAT-1:0] r_vld;
    t_side               r_side [NORM_LAT];

    logic [2:0][62:0] r_mag1, r_mag2, r_mag3;
    logic [2:0]       r_sgn1, r_sgn2, r_sgn3, r_sgn4, r_sgn5;
    logic             r_nz2, r_nz3, r_nz4, r_nz5;
    logic [1:0]       r_chk2;
    logic [15:0]      r_grp2;
    logic [5:0]       r_p3;
    logic [2:0][30:0] r_sm4, r_sm5;
    logic [2:0][61:0] r_sq5;

    logic [35:0] r_srem  [SQ+1];
    logic [31:0] r_sroot [SQ+1];
    logic [63:0] r_sn    [SQ+1];
    t_meta       r_smeta [SQ+1];

    logic [2:0][31:0] r_drem [DV+1];
    logic [2:0][30:0] r_dnum [DV+1];
    logic [2:0][30:0] r_dq   [DV+1];
    logic [31:0]      r_dlen [DV+1];
    logic [2:0]       r_dsg  [DV+1];
    logic             r_dnz  [DV+1];

    logic [2:0][31:0] r_out;
    logic             r_onz;

    logic [2:0][62:0] n_mag1;
    logic [62:0]      n_m01, n_m;
    logic [1:0]       n_chk;
    logic [15:0]      n_grp;
    logic [3:0]       n_pos;
    logic [2:0][30:0] n_sm;
    logic [35:0]      n_srem  [SQ];
    logic [31:0]      n_sroot [SQ];
    logic [2:0][61:0] n_num;
    logic [2:0][31:0] n_drem [DV];
    logic [2:0][30:0] n_dq   [DV];
    logic [2:0][31:0] n_out;

    always_comb begin
        logic [63:0] neg;
        logic [35:0] rin;
        logic [35:0] trial;
        logic [32:0] drin;
        logic        ge;
        for (int i = 0; i < 3; i++) begin
            neg = 64'd0 - i_vec[i];
            n_mag1[i] = i_vec[i][63] ? neg[62:0] : i_vec[i][62:0];
        end
        // largest magnitude, then the highest nonzero 16 bit group
        n_m01 = (r_mag1[0] > r_mag1[1]) ? r_mag1[0] : r_mag1[1];
        n_m   = (n_m01 > r_mag1[2]) ? n_m01 : r_mag1[2];
        if (n_m[62:48] != 15'd0) begin
            n_chk = 2'd3;
            n_grp = {1'b0, n_m[62:48]};
        end else if (n_m[47:32] != 16'd0) begin
            n_chk = 2'd2;
            n_grp = n_m[47:32];
        end else if (n_m[31:16] != 16'd0) begin
            n_chk = 2'd1;
            n_grp = n_m[31:16];
        end else begin
            n_chk = 2'd0;
            n_grp = n_m[15:0];
        end
        n_pos = 4'd0;
        for (int b = 0; b < 16; b++) begin
            if (r_grp2[b]) n_pos = 4'(b);
        end
        // bring the largest magnitude into [2^30, 2^31)
        for (int i = 0; i < 3; i++) begin
            if (r_p3 > 6'd30) n_sm[i] = 31'(r_mag3[i] >> (6'(r_p3 - 6'd30)));
            else              n_sm[i] = 31'(r_mag3[i] << (6'(6'd30 - r_p3)));
        end
        // one root bit per stage
        for (int k = 0; k < SQ; k++) begin
            rin   = {r_srem[k][33:0], r_sn[k][63:62]};
            trial = {2'b00, r_sroot[k], 2'b01};
            ge    = (rin >= trial);
            n_srem[k]  = ge ? (rin - trial) : rin;
            n_sroot[k] = {r_sroot[k][30:0], ge};
        end
        for (int i = 0; i < 3; i++) begin
            n_num[i] = {r_smeta[SQ].sm[i], 30'd0} + 62'(r_sroot[SQ] >> 1);
        end
        // one quotient bit per stage
        for (int k = 0; k < DV; k++) begin
            for (int i = 0; i < 3; i++) begin
                drin = {r_drem[k][i], r_dnum[k][i][30]};
                ge   = (drin >= {1'b0, r_dlen[k]});
                n_drem[k][i] = ge ? 32'(drin - {1'b0, r_dlen[k]}) : drin[31:0];
                n_dq[k][i]   = {r_dq[k][i][29:0], ge};
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (!r_dnz[DV])        n_out[i] = 32'd0;
            else if (r_dsg[DV][i]) n_out[i] = 32'd0 - {1'b0, r_dq[DV][i]};
            else                   n_out[i] = {1'b0, r_dq[DV][i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[NORM_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_side[0] <= i_side;
            for (int k = 1; k < NORM_LAT; k++) r_side[k] <= r_side[k-1];

            r_mag1 <= n_mag1;
            for (int i = 0; i < 3; i++) r_sgn1[i] <= i_vec[i][63];

            r_mag2 <= r_mag1;
            r_sgn2 <= r_sgn1;
            r_nz2  <= (n_m != 63'd0);
            r_chk2 <= n_chk;
            r_grp2 <= n_grp;

            r_mag3 <= r_mag2;
            r_sgn3 <= r_sgn2;
            r_nz3  <= r_nz2;
            r_p3   <= {r_chk2, n_pos};

            r_sm4  <= n_sm;
            r_sgn4 <= r_sgn3;
            r_nz4  <= r_nz3;

            for (int i = 0; i < 3; i++) r_sq5[i] <= 62'(r_sm4[i]) * 62'(r_sm4[i]);
            r_sm5  <= r_sm4;
            r_sgn5 <= r_sgn4;
            r_nz5  <= r_nz4;

            r_sn[0]        <= 64'(r_sq5[0]) + 64'(r_sq5[1]) + 64'(r_sq5[2]);
            r_srem[0]      <= '0;
            r_sroot[0]     <= '0;
            r_smeta[0].sm  <= r_sm5;
            r_smeta[0].sgn <= r_sgn5;
            r_smeta[0].nz  <= r_nz5;
            for (int k = 0; k < SQ; k++) begin
                r_srem[k+1]  <= n_srem[k];
                r_sroot[k+1] <= n_sroot[k];
                r_sn[k+1]    <= {r_sn[k][61:0], 2'b00};
                r_smeta[k+1] <= r_smeta[k];
            end

            for (int i = 0; i < 3; i++) begin
                r_drem[0][i] <= {1'b0, n_num[i][61:31]};
                r_dnum[0][i] <= n_num[i][30:0];
                r_dq[0][i]   <= '0;
            end
            r_dlen[0] <= r_sroot[SQ];
            r_dsg[0]  <= r_smeta[SQ].sgn;
            r_dnz[0]  <= r_smeta[SQ].nz;
            for (int k = 0; k < DV; k++) begin
                r_drem[k+1] <= n_drem[k];
                for (int i = 0; i < 3; i++) r_dnum[k+1][i] <= {r_dnum[k][i][29:0], 1'b0};
                r_dq[k+1]   <= n_dq[k];
                r_dlen[k+1] <= r_dlen[k];
                r_dsg[k+1]  <= r_dsg[k];
                r_dnz[k+1]  <= r_dnz[k];
            end

            r_out <= n_out;
            r_onz <= r_dnz[DV];
        end
    end

    assign o_valid = r_vld[NORM_LAT-1];
    assign o_side  = r_side[NORM_LAT-1];
    assign o_vec   = r_out;
    assign o_ok    = r_onz;

endmodule

@@ hdl/look_at_view_matrix_top.sv @@
// Look-at view matrix generator: input stage, three normalisers, translation, row output.
// Usage:
//   Slave stream takes one camera item: eye, target and up vector, nine signed
//   Q16.16 words in s_axis_tdata. Master stream returns three rows per item,
//   side, up and back in that order; tlast marks the back row.
//   Each row carries three Q1.30 rotation entries and a saturated Q16.16
//   translation; tuser holds the row index and the degenerate flag.
//   Configuration is a plain write port (mode, height, roll), written while idle.
// The first row of an item leaves after the input register, the three normalisers
//   with their cross-product and translation registers and the output register;
//   the other two rows follow as the receiver takes them. Output of three rows per
//   item bounds throughput; the pipeline takes an item each cycle while tready is high.
// Reset clears all valid bits, the mode and roll, sets the height to 0.5, and
//   starts the sine/cosine computation; tready stays low during it.
//   Every write of the roll register restarts that computation.
// When the receiver stalls, the held row stays put, the pipeline freezes once
//   a finished item waits behind it, and tready drops with it.
`timescale 1ns / 1ps
`include "look_at_view_matrix_top_assert.svh"
module look_at_view_matrix_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
    input  logic [287:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // col0, col1, col2, translation
    output logic [127:0] m_axis_tdata,
    // row_index, degenerate
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import lav_pkg::*;

    // configuration and roll sine/cosine
    logic                r_mode;
    logic [31:0]         r_height;
    logic [15:0]         r_roll;
    logic                r_cbusy;
    logic [4:0]          r_ci;
    logic signed [33:0]  r_cx, r_cy;
    logic signed [31:0]  r_cz;
    logic signed [33:0]  n_cx, n_cy;
    logic signed [31:0]  n_cz;
    logic [31:0]         w_atan, w_sin, w_cos;

    logic ce, ser_free, accept;

    logic             r_f0_vld;
    logic [2:0][63:0] r_f0_d;
    t_side            r_f0_side;
    t_side            n_f0_side;
    logic [2:0][63:0] n_f0_d;

    logic             a_vld, b_vld, c_vld, a_ok, b_ok, c_ok;
    logic [2:0][31:0] a_vec, b_vec, c_vec;
    t_side            a_side, b_side, c_side;

    logic             r_c1a_vld, r_c1b_vld, r_c2a_vld, r_c2b_vld;
    logic [5:0][63:0] r_c1a_p, r_c2a_p;
    t_side            r_c1a_side, r_c1b_side, r_c2a_side, r_c2b_side;
    t_side            n_c1a_side, n_c2a_side;
    logic [2:0][63:0] r_c1b_v, r_c2b_v;

    logic                  r_t1_vld, r_t2_vld, r_t3_vld;
    logic [2:0][2:0][31:0] r_t1_rows, r_t2_rows, r_t3_rows;
    logic [2:0][2:0][63:0] r_t1_p;
    logic [2:0][63:0]      r_t2_d;
    logic [2:0][31:0]      r_t3_tr, n_t3_tr;
    logic                  r_t1_ok, r_t2_ok, r_t3_ok;
    logic [2:0][2:0][31:0] n_t1_rows;

    logic                  r_ovalid;
    logic [1:0]            r_cnt;
    logic [2:0][2:0][31:0] r_orows;
    logic [2:0][31:0]      r_otr;
    logic                  r_odeg;

    // ---------------- configuration and CORDIC ----------------
    assign w_atan = atan_entry(r_ci);

    always_comb begin
        if (!r_cz[31]) begin
            n_cx = r_cx - (r_cy >>> r_ci);
            n_cy = r_cy + (r_cx >>> r_ci);
            n_cz = r_cz - $signed(w_atan);
        end else begin
            n_cx = r_cx + (r_cy >>> r_ci);
            n_cy = r_cy - (r_cx >>> r_ci);
            n_cz = r_cz + $signed(w_atan);
        end
        // apply the quadrant by swap and negate
        case (r_roll[15:14])
            2'd0: begin
                w_sin = 32'(r_cy);
                w_cos = 32'(r_cx);
            end
            2'd1: begin
                w_sin = 32'(r_cx);
                w_cos = 32'(34'sd0 - r_cy);
            end
            2'd2: begin
                w_sin = 32'(34'sd0 - r_cy);
                w_cos = 32'(34'sd0 - r_cx);
            end
            default: begin
                w_sin = 32'(34'sd0 - r_cx);
                w_cos = 32'(r_cy);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_height <= HEIGHT_RESET;
            r_roll   <= 16'd0;
            r_cbusy  <= 1'b1;
            r_ci     <= 5'd0;
            r_cx     <= CORDIC_GAIN;
            r_cy     <= 34'sd0;
            r_cz     <= 32'sd0;
        end else begin
            if (r_cbusy) begin
                r_cx <= n_cx;
                r_cy <= n_cy;
                r_cz <= n_cz;
                r_ci <= r_ci + 5'd1;
                if (r_ci == CORDIC_LAST) r_cbusy <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ORTHO_MODE:   r_mode   <= i_cfg_data[0];
                    CFG_ORTHO_HEIGHT: r_height <= i_cfg_data;
                    CFG_ORTHO_ROLL: begin
                        // restart the rotation on the new angle
                        r_roll  <= i_cfg_data[15:0];
                        r_cbusy <= 1'b1;
                        r_ci    <= 5'd0;
                        r_cx    <= CORDIC_GAIN;
                        r_cy    <= 34'sd0;
                        r_cz    <= $signed({2'b00, i_cfg_data[13:0], 16'd0});
                    end
                    default: ;
                endcase
            end
        end
    end

    // ---------------- flow control ----------------
    assign ser_free      = !r_ovalid || (m_axis_tready && (r_cnt == ROW_BACK));
    assign ce            = !r_t3_vld || ser_free;
    assign s_axis_tready = ce && !r_cbusy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ---------------- input stage ----------------
    always_comb begin
        logic [31:0] ev;
        logic [31:0] tv;
        n_f0_side = '0;
        for (int i = 0; i < 3; i++) begin
            n_f0_side.eye[i] = s_axis_tdata[32*i +: 32];
            n_f0_side.up[i]  = s_axis_tdata[32*(6+i) +: 32];
        end
        if (r_mode) begin
            n_f0_side.eye[0] = s_axis_tdata[32*3 +: 32];
            n_f0_side.eye[1] = s_axis_tdata[32*4 +: 32];
            n_f0_side.eye[2] = r_height;
            n_f0_side.up[0]  = w_sin;
            n_f0_side.up[1]  = w_cos;
            n_f0_side.up[2]  = 32'd0;
        end
        for (int i = 0; i < 3; i++) begin
            ev = n_f0_side.eye[i];
            tv = s_axis_tdata[32*(3+i) +: 32];
            n_f0_d[i] = {{32{ev[31]}}, ev} - {{32{tv[31]}}, tv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_vld  <= 1'b0;
            r_c1a_vld <= 1'b0;
            r_c1b_vld <= 1'b0;
            r_c2a_vld <= 1'b0;
            r_c2b_vld <= 1'b0;
            r_t1_vld  <= 1'b0;
            r_t2_vld  <= 1'b0;
            r_t3_vld  <= 1'b0;
        end else if (ce) begin
            r_f0_vld  <= accept;
            r_c1a_vld <= a_vld;
            r_c1b_vld <= r_c1a_vld;
            r_c2a_vld <= b_vld;
            r_c2b_vld <= r_c2a_vld;
            r_t1_vld  <= c_vld;
            r_t2_vld  <= r_t1_vld;
            r_t3_vld  <= r_t2_vld;
        end
    end

    lav_norm u_norm_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r_f0_vld),
        .i_vec   (r_f0_d),
        .i_side  (r_f0_side),
        .o_valid (a_vld),
        .o_vec   (a_vec),
        .o_ok    (a_ok),
        .o_side  (a_side)
    );

    lav_norm u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r_c1b_vld),
        .i_vec   (r_c1b_v),
        .i_side  (r_c1b_side),
        .o_valid (b_vld),
        .o_vec   (b_vec),
        .o_ok    (b_ok),
        .o_side  (b_side)
    );

    lav_norm u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r_c2b_vld),
        .i_vec   (r_c2b_v),
        .i_side  (r_c2b_side),
        .o_valid (c_vld),
        .o_vec   (c_vec),
        .o_ok    (c_ok),
        .o_side  (c_side)
    );

    // merge the back and side normaliser results into the data that rides along
    always_comb begin
        n_c1a_side      = a_side;
        n_c1a_side.back = a_vec;
        n_c1a_side.ok   = a_ok;
        n_c2a_side      = b_side;
        n_c2a_side.side = b_vec;
        n_c2a_side.ok   = b_side.ok & b_ok;
    end

    always_comb begin
        n_t1_rows[ROW_SIDE] = c_side.side;
        n_t1_rows[ROW_UP]   = c_vec;
        n_t1_rows[ROW_BACK] = c_side.back;
        for (int r = 0; r < 3; r++) begin
            logic        neg;
            logic [63:0] d;
            logic [63:0] mag;
            logic [33:0] rr;
            d   = r_t2_d[r];
            neg = d[63];
            mag = neg ? (64'd0 - d) : d;
            rr  = 34'((mag + 64'(1 << 29)) >> 30);
            // round half away from zero, then clamp to 32 bits
            if (!neg) n_t3_tr[r] = (rr > 34'h7FFFFFFF) ? 32'h7FFFFFFF : rr[31:0];
            else      n_t3_tr[r] = (rr > 34'h80000000) ? 32'h80000000 : 32'(34'd0 - rr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_f0_d    <= n_f0_d;
            r_f0_side <= n_f0_side;

            // up x back
            r_c1a_p[0] <= mul32(a_side.up[1], a_vec[2]);
            r_c1a_p[1] <= mul32(a_side.up[2], a_vec[1]);
            r_c1a_p[2] <= mul32(a_side.up[2], a_vec[0]);
            r_c1a_p[3] <= mul32(a_side.up[0], a_vec[2]);
            r_c1a_p[4] <= mul32(a_side.up[0], a_vec[1]);
            r_c1a_p[5] <= mul32(a_side.up[1], a_vec[0]);
            r_c1a_side <= n_c1a_side;

            r_c1b_v[0] <= r_c1a_p[0] - r_c1a_p[1];
            r_c1b_v[1] <= r_c1a_p[2] - r_c1a_p[3];
            r_c1b_v[2] <= r_c1a_p[4] - r_c1a_p[5];
            r_c1b_side <= r_c1a_side;

            // back x side
            r_c2a_p[0] <= mul32(b_side.back[1], b_vec[2]);
            r_c2a_p[1] <= mul32(b_side.back[2], b_vec[1]);
            r_c2a_p[2] <= mul32(b_side.back[2], b_vec[0]);
            r_c2a_p[3] <= mul32(b_side.back[0], b_vec[2]);
            r_c2a_p[4] <= mul32(b_side.back[0], b_vec[1]);
            r_c2a_p[5] <= mul32(b_side.back[1], b_vec[0]);
            r_c2a_side <= n_c2a_side;

            r_c2b_v[0] <= r_c2a_p[0] - r_c2a_p[1];
            r_c2b_v[1] <= r_c2a_p[2] - r_c2a_p[3];
            r_c2b_v[2] <= r_c2a_p[4] - r_c2a_p[5];
            r_c2b_side <= r_c2a_side;

            for (int r = 0; r < 3; r++) begin
                for (int i = 0; i < 3; i++) begin
                    r_t1_p[r][i] <= mul32(n_t1_rows[r][i], c_side.eye[i]);
                end
            end
            r_t1_rows <= n_t1_rows;
            r_t1_ok   <= c_side.ok & c_ok;

            for (int r = 0; r < 3; r++) begin
                r_t2_d[r] <= 64'd0 - (r_t1_p[r][0] + r_t1_p[r][1] + r_t1_p[r][2]);
            end
            r_t2_rows <= r_t1_rows;
            r_t2_ok   <= r_t1_ok;

            r_t3_tr   <= n_t3_tr;
            r_t3_rows <= r_t2_rows;
            r_t3_ok   <= r_t2_ok;
        end
    end

    // ---------------- row output ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_cnt    <= ROW_SIDE;
        end else if (ce && r_t3_vld) begin
            r_ovalid <= 1'b1;
            r_cnt    <= ROW_SIDE;
        end else if (r_ovalid && m_axis_tready) begin
            if (r_cnt == ROW_BACK) r_ovalid <= 1'b0;
            else                   r_cnt    <= r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce && r_t3_vld) begin
            r_orows <= r_t3_rows;
            r_otr   <= r_t3_tr;
            r_odeg  <= !r_t3_ok;
        end
    end

    always_comb begin
        case (r_cnt)
            ROW_SIDE: m_axis_tdata = {r_otr[0], r_orows[0][2], r_orows[0][1], r_orows[0][0]};
            ROW_UP:   m_axis_tdata = {r_otr[1], r_orows[1][2], r_orows[1][1], r_orows[1][0]};
            ROW_BACK: m_axis_tdata = {r_otr[2], r_orows[2][2], r_orows[2][1], r_orows[2][0]};
            default:  m_axis_tdata = '0;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = {r_odeg, r_cnt};
    assign m_axis_tlast  = (r_cnt == ROW_BACK);

    // ---------------- checks ----------------
    `LAV_ASSERT_IMPL(a_no_take_in_cordic, r_cbusy, !s_axis_tready)
    `LAV_ASSERT_NEXT(a_row_held_on_stall, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(r_cnt))
    `LAV_ASSERT_NEXT(a_drain_after_back,
                     m_axis_tvalid && m_axis_tready && (r_cnt == ROW_BACK) && !r_t3_vld,
                     !m_axis_tvalid)
    `LAV_ASSERT_IMPL(a_degen_up_zero,
                     m_axis_tvalid && m_axis_tuser[2] && (r_cnt == ROW_UP),
                     m_axis_tdata == 128'd0)

endmodule

@@ dv/tb_look_at_view_matrix_top.sv @@
// Testbench for the look-at view matrix block: predicts each row and checks it on the stream.
`timescale 1ns / 1ps
module tb_look_at_view_matrix_top;
    import lav_pkg::*;

    // register index that no register answers to
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  row_index;
        logic [31:0] col0;
        logic [31:0] col1;
        logic [31:0] col2;
        logic [31:0] translation;
        logic        degenerate;
        logic        last_row;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_idx = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;

    look_at_view_matrix_top u_top (.*);

    always #1 i_clk = ~i_clk;

    t_row        row_q[$];
    int          err_cnt = 0;
    bit          hold_off = 1'b0;
    logic        mode_r = 1'b0;
    logic [31:0] height_r = 32'h8000;
    logic [15:0] roll_r = '0;

    longint atan_v[30] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
        'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
        'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2F9,
        'h0000517C, 'h000028BE, 'h0000145F, 'h00000A2F, 'h00000517,
        'h0000028B, 'h00000145, 'h000000A2, 'h00000051, 'h00000028,
        'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001};

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(longint unsigned n);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt >>= 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic bit unit_vec(input longint v[3], output longint o[3]);
        longint unsigned mag[3], m, sum, len, q;
        int p;
        m = 0;
        sum = 0;
        p = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = v[i] < 0 ? longint'(-v[i]) : v[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            o = '{0, 0, 0};
            return 1'b0;
        end
        while (p < 63 && (m >> (p + 1)) != 0) p++;
        for (int i = 0; i < 3; i++) begin
            if (p > 30) mag[i] >>= (p - 30);
            else mag[i] <<= (30 - p);
            sum += mag[i] * mag[i];
        end
        len = isqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 30) + (len >> 1)) / len;
            o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3], output longint o[3]);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic void roll_sin_cos(input logic [15:0] roll, output longint s,
                                         output longint c);
        logic [31:0] a;
        longint z, x, y, nx;
        a = {roll, 16'h0};
        z = a[29:0];
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
                nx = x - fshr(y, i);
                y = y + fshr(x, i);
                z -= atan_v[i];
            end else begin
                nx = x + fshr(y, i);
                y = y - fshr(x, i);
                z += atan_v[i];
            end
            x = nx;
        end
        case (a[31:30])
            2'd0: begin s = y;  c = x;  end
            2'd1: begin s = x;  c = -y; end
            2'd2: begin s = -y; c = -x; end
            default: begin s = -x; c = y; end
        endcase
    endfunction

    function automatic longint row_shift(input longint r[3], input longint e[3]);
        longint d, q;
        longint unsigned mag;
        d = -(r[0] * e[0] + r[1] * e[1] + r[2] * e[2]);
        mag = d < 0 ? longint'(-d) : d;
        q = longint'((mag + (64'd1 << 29)) >> 30);
        if (d < 0) q = -q;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q;
    endfunction

    // Build the three expected rows of one camera item
    function automatic void predict_matrix(input logic [287:0] d);
        longint eye[3], tgt[3], up[3], dv[3], t[3], side[3], upr[3], back[3];
        bit ok;
        t_row r;
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'($signed(d[32*i +: 32]));
            tgt[i] = longint'($signed(d[32*(3+i) +: 32]));
            up[i]  = longint'($signed(d[32*(6+i) +: 32]));
        end
        if (mode_r) begin
            eye[0] = tgt[0];
            eye[1] = tgt[1];
            eye[2] = longint'($signed(height_r));
            roll_sin_cos(roll_r, up[0], up[1]);
            up[2] = 0;
        end
        for (int i = 0; i < 3; i++) dv[i] = eye[i] - tgt[i];
        ok = unit_vec(dv, back);
        cross3(up, back, t);
        ok &= unit_vec(t, side);
        cross3(back, side, t);
        ok &= unit_vec(t, upr);
        for (int k = 0; k < 3; k++) begin
            longint rv[3];
            case (k)
                0: rv = side;
                1: rv = upr;
                default: rv = back;
            endcase
            r.row_index = 2'(k);
            r.col0 = rv[0][31:0];
            r.col1 = rv[1][31:0];
            r.col2 = rv[2][31:0];
            r.translation = 32'(row_shift(rv, eye));
            r.degenerate = ~ok;
            r.last_row = k == 2;
            row_q.push_back(r);
        end
    endfunction

    task automatic report_err(input string what);
        $display("mismatch: %s at %0t", what, $realtime);
        err_cnt++;
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // Offer one item; tvalid stays high after the handshake until a gap, drain or the caller drops it
    task automatic send_item(input logic [287:0] d);
        int n;
        n = gap_len();
        if (n != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        predict_matrix(d);
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ORTHO_MODE:   mode_r = v[0];
            CFG_ORTHO_HEIGHT: height_r = v;
            CFG_ORTHO_ROLL:   roll_r = v[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (row_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 8191)) - 4096);
            3: return $urandom() >>> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [287:0] rnd_item();
        logic [287:0] d;
        for (int i = 0; i < 9; i++) d[32*i +: 32] = rnd_word();
        // eye equal to target now and then
        if ($urandom_range(0, 9) == 0) d[95:0] = d[191:96];
        return d;
    endfunction

    task automatic test_directed();
        logic [287:0] d;
        d = '0;
        d[32*2 +: 32] = 32'h10000;
        d[32*7 +: 32] = 32'h10000;
        send_item(d);
        send_item('0);
        d = '0;
        d[32*7 +: 32] = 32'h10000;
        send_item(d);
        d = '0;
        d[32*2 +: 32] = 32'h10000;
        d[32*8 +: 32] = 32'h10000;
        send_item(d);
        send_item({9{32'h7FFFFFFF}});
        send_item({9{32'h80000000}});
        d = '0;
        d[191:96] = {3{32'h80000000}};
        d[95:0] = {3{32'h7FFFFFFF}};
        send_item(d);
        d = {32'h1, 32'h7FFFFFFF, 32'h80000000, 96'h0, 32'h7FFFFFFF, 32'h80000000,
             32'h7FFFFFFF};
        send_item(d);
        d = '1;
        send_item(d);
        for (int i = 0; i < 6; i++) send_item(rnd_item());
        drain();
    endtask

    task automatic test_ortho();
        logic [15:0] rolls[6] = '{16'h0, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2345};
        write_reg(CFG_ORTHO_MODE, 32'h1);
        foreach (rolls[k]) begin
            write_reg(CFG_ORTHO_ROLL, {16'($urandom_range(0, 65535)), rolls[k]});
            write_reg(CFG_ORTHO_HEIGHT, k == 1 ? 32'h7FFFFFFF : (k == 2 ? 32'h80000000 :
                      (k == 3 ? 32'h0 : rnd_word())));
            repeat (3) send_item(rnd_item());
            drain();
        end
        write_reg(CFG_UNUSED, $urandom());
        write_reg(CFG_ORTHO_MODE, 32'hFFFFFFFE);
    endtask

    task automatic test_random();
        for (int i = 0; i < 65; i++) begin
            if (i == 32) begin
                drain();
                write_reg(CFG_ORTHO_MODE, $urandom());
                write_reg(CFG_ORTHO_ROLL, $urandom());
                write_reg(CFG_ORTHO_HEIGHT, rnd_word());
            end
            send_item(rnd_item());
        end
    endtask

    // Items spread out during the receiver's long hold-off, so the pipeline fills and the input stalls
    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_item(rnd_item());
            s_axis_tvalid <= 1'b0;
            repeat (25) @(posedge i_clk);
        end
        hold_off = 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            n = gap_len();
            if (n != 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_row e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (row_q.size() == 0) begin
                report_err("row with nothing expected");
            end else begin
                e = row_q.pop_front();
                if (m_axis_tuser[1:0] !== e.row_index) report_err("row_index");
                if (m_axis_tdata[31:0] !== e.col0) report_err("col0");
                if (m_axis_tdata[63:32] !== e.col1) report_err("col1");
                if (m_axis_tdata[95:64] !== e.col2) report_err("col2");
                if (m_axis_tdata[127:96] !== e.translation) report_err("translation");
                if (m_axis_tuser[2] !== e.degenerate) report_err("degenerate");
                if (m_axis_tlast !== e.last_row) report_err("last_row");
            end
        end
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        drain();
        test_ortho();
        drain();
        test_random();
        drain();
        repeat (250) @(posedge i_clk);
        if (err_cnt == 0 && row_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

@@ look_at_view_matrix_top.f @@
+incdir+hdl
hdl/lav_pkg.sv
hdl/lav_norm.sv
hdl/look_at_view_matrix_top.sv
dv/tb_look_at_view_matrix_top.sv
